// ===== hdl/cps_pkg.sv =====
// Shared types and constants for the complement pair search unit.
// No dependencies; used by every module of the block.
package cps_pkg;

	// Width of one array element and of the stored values.
	localparam int VALUE_W = 32;
	// Width of the reported positions.
	localparam int INDEX_W = 8;
	// Default number of entries in the value memory.
	localparam int DEFAULT_TABLE_DEPTH = 256;

	// Result codes carried in tuser.
	typedef enum logic [1:0] {
		STATUS_PAIR     = 2'd0,
		STATUS_NONE     = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	// Search controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_EMIT
	} state_t;

endpackage

// ===== hdl/complement_pair_search_unit.sv =====
// Top level of the complement pair search unit.
// Depends on cps_pkg, cps_value_ram and cps_search_ctrl.
//
// The block takes one array per frame of signed 32-bit words (tlast marks the
// final word) and looks for the first element whose complement, target minus
// value taken at 33 bits, equals an earlier element. The search is a linear
// scan of the value memory at one entry per clock, and the single read port of
// the memory sets the cost of a word: a word is compared against the stored
// elements up to its partner or up to the last stored one. The first word of
// an array, words after a pair and words beyond TABLE_DEPTH skip the scan. A
// word that completes a result passes through the emit state to the output
// register, and waits there while that register still holds an earlier
// result that has not been taken. A result word leaves through an output
// register, and a new input word is taken while it waits. The table needs no
// clearing pass: a fill count marks the stored entries, and it is reset at the
// end of every array.
module complement_pair_search_unit #(
	parameter int TABLE_DEPTH = cps_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Target sum register.
	input  logic                        cfg_we,
	input  logic [cps_pkg::VALUE_W-1:0] cfg_wdata,
	// Input stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // [31:0] value
	input  logic                        s_tlast,
	// Result stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,   // [7:0] first_index, [15:8] second_index
	output logic [1:0]                  m_tuser    // [1:0] status
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [cps_pkg::VALUE_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [cps_pkg::VALUE_W-1:0] mem_rdata;
	cps_pkg::status_t            out_status;
	logic [cps_pkg::INDEX_W-1:0] out_first;
	logic [cps_pkg::INDEX_W-1:0] out_second;

	// Search controller.
	cps_search_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_value(s_tdata),
		.in_last(s_tlast),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_status(out_status),
		.out_first(out_first),
		.out_second(out_second),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// Value memory.
	cps_value_ram #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Pack the result word.
	assign m_tdata = {out_second, out_first};
	assign m_tuser = out_status;

endmodule

// ===== hdl/cps_value_ram.sv =====
// Value memory of the complement pair search unit: one write port and one
// read port with a registered read. Depends on cps_pkg for the value width.
module cps_value_ram #(
	parameter int TABLE_DEPTH = cps_pkg::DEFAULT_TABLE_DEPTH,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [cps_pkg::VALUE_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [cps_pkg::VALUE_W-1:0] rdata
);

	logic [cps_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];
	logic [cps_pkg::VALUE_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with a registered output.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/cps_search_ctrl.sv =====
// Search controller: holds the target register, the fill count and the flags,
// scans the value memory and drives the result register.
// Depends on cps_pkg; drives the ports of cps_value_ram.
module cps_search_ctrl #(
	parameter int TABLE_DEPTH = cps_pkg::DEFAULT_TABLE_DEPTH,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration.
	input  logic                        cfg_we,
	input  logic [cps_pkg::VALUE_W-1:0] cfg_wdata,
	// Input words.
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cps_pkg::VALUE_W-1:0] in_value,
	input  logic                        in_last,
	// Result words.
	output logic                        out_valid,
	input  logic                        out_ready,
	output cps_pkg::status_t            out_status,
	output logic [cps_pkg::INDEX_W-1:0] out_first,
	output logic [cps_pkg::INDEX_W-1:0] out_second,
	// Value memory.
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [cps_pkg::VALUE_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [cps_pkg::VALUE_W-1:0] mem_rdata
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int XW = (CW > cps_pkg::INDEX_W) ? CW : cps_pkg::INDEX_W;
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

	cps_pkg::state_t state_q, state_n;

	logic [cps_pkg::VALUE_W-1:0] target_q;
	logic [CW-1:0]               count_q, count_n;
	logic                        pair_q, pair_n;
	logic                        exceed_q, exceed_n;
	logic [cps_pkg::VALUE_W:0]   want_q, want_n;
	logic [cps_pkg::VALUE_W-1:0] value_q, value_n;
	logic                        last_q, last_n;
	logic [CW-1:0]               ptr_q, ptr_n;
	logic                        cmp_v_q, cmp_v_n;
	logic [AW-1:0]               cmp_idx_q, cmp_idx_n;
	logic                        pend_q, pend_n;
	cps_pkg::status_t            res_status_q, res_status_n;
	logic [cps_pkg::INDEX_W-1:0] res_first_q, res_first_n;
	logic [cps_pkg::INDEX_W-1:0] res_second_q, res_second_n;
	logic                        out_valid_q;
	cps_pkg::status_t            out_status_q;
	logic [cps_pkg::INDEX_W-1:0] out_first_q, out_second_q;

	logic                        accept;
	logic                        out_free;
	logic                        load_out;
	logic                        hit;
	logic                        scan_end;
	logic [XW-1:0]               cmp_idx_wide;
	logic [XW-1:0]               count_wide;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Positions are reported modulo 256.
	assign cmp_idx_wide = XW'(cmp_idx_q);
	assign count_wide   = XW'(count_q);

	// A stored value matches when its sign extension equals the complement.
	assign hit      = cmp_v_q && ({mem_rdata[cps_pkg::VALUE_W-1], mem_rdata} == want_q);
	assign scan_end = cmp_v_q && ((CW'(cmp_idx_q) + CW'(1)) == count_q);

	// Target register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	// Next state, memory accesses and result assembly.
	always_comb begin
		state_n      = state_q;
		count_n      = count_q;
		pair_n       = pair_q;
		exceed_n     = exceed_q;
		want_n       = want_q;
		value_n      = value_q;
		last_n       = last_q;
		ptr_n        = ptr_q;
		cmp_v_n      = 1'b0;
		cmp_idx_n    = cmp_idx_q;
		pend_n       = pend_q;
		res_status_n = res_status_q;
		res_first_n  = res_first_q;
		res_second_n = res_second_q;
		in_ready     = 1'b0;
		load_out     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = count_q[AW-1:0];
		mem_wdata    = value_q;
		mem_re       = 1'b0;
		mem_raddr    = ptr_q[AW-1:0];
		case (state_q)
			cps_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					value_n = in_value;
					last_n  = in_last;
					want_n  = {target_q[cps_pkg::VALUE_W-1], target_q}
						- {in_value[cps_pkg::VALUE_W-1], in_value};
					ptr_n   = '0;
					state_n = cps_pkg::ST_FINISH;
					if (pair_q || exceed_q) begin
						// Rest of the array is skipped.
					end else if (count_q == FULL_COUNT) begin
						exceed_n = 1'b1;
					end else if (count_q == '0) begin
						// Nothing to search: store straight away.
						mem_we    = 1'b1;
						mem_wdata = in_value;
						count_n   = count_q + CW'(1);
					end else begin
						state_n = cps_pkg::ST_SCAN;
					end
				end
			end
			cps_pkg::ST_SCAN: begin
				// One read issued per cycle, compared in the next cycle.
				if (ptr_q < count_q && !hit) begin
					mem_re    = 1'b1;
					ptr_n     = ptr_q + CW'(1);
					cmp_v_n   = 1'b1;
					cmp_idx_n = ptr_q[AW-1:0];
				end
				if (hit) begin
					pend_n       = 1'b1;
					pair_n       = 1'b1;
					res_status_n = cps_pkg::STATUS_PAIR;
					res_first_n  = cmp_idx_wide[cps_pkg::INDEX_W-1:0];
					res_second_n = count_wide[cps_pkg::INDEX_W-1:0];
					state_n      = cps_pkg::ST_FINISH;
				end else if (scan_end) begin
					mem_we  = 1'b1;
					count_n = count_q + CW'(1);
					state_n = cps_pkg::ST_FINISH;
				end
			end
			cps_pkg::ST_FINISH: begin
				// End of an array: report a missing pair or an overflow, and reset the fill count and flags.
				if (last_q) begin
					if (!pend_q && !pair_q) begin
						pend_n       = 1'b1;
						res_status_n = exceed_q ? cps_pkg::STATUS_OVERFLOW
							: cps_pkg::STATUS_NONE;
						res_first_n  = '0;
						res_second_n = '0;
					end
					count_n  = '0;
					pair_n   = 1'b0;
					exceed_n = 1'b0;
				end
				if (pend_n) begin
					state_n = cps_pkg::ST_EMIT;
				end else begin
					state_n = cps_pkg::ST_IDLE;
				end
			end
			cps_pkg::ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					pend_n   = 1'b0;
					state_n  = cps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = cps_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cps_pkg::ST_IDLE;
			count_q  <= '0;
			pair_q   <= 1'b0;
			exceed_q <= 1'b0;
			cmp_v_q  <= 1'b0;
			pend_q   <= 1'b0;
			ptr_q    <= '0;
		end else begin
			state_q  <= state_n;
			count_q  <= count_n;
			pair_q   <= pair_n;
			exceed_q <= exceed_n;
			cmp_v_q  <= cmp_v_n;
			pend_q   <= pend_n;
			ptr_q    <= ptr_n;
		end
	end

	// Payload registers of the item in work.
	always_ff @(posedge clk) begin
		want_q       <= want_n;
		value_q      <= value_n;
		last_q       <= last_n;
		cmp_idx_q    <= cmp_idx_n;
		res_status_q <= res_status_n;
		res_first_q  <= res_first_n;
		res_second_q <= res_second_n;
	end

	// Result register towards the output side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_first_q  <= res_first_q;
			out_second_q <= res_second_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_first  = out_first_q;
	assign out_second = out_second_q;

	// The fill count never passes the memory depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("fill count beyond table depth");

	// A pair and an overflow are never recorded for the same array.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(pair_q && exceed_q))
		else $error("pair and overflow both set");

	// Reads stay below the fill count and never meet the write address.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (ptr_q < count_q) && !(mem_we && mem_waddr == mem_raddr))
		else $error("memory read outside stored entries");

	// A new result only comes from the emit state.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> state_q == cps_pkg::ST_EMIT && pend_q)
		else $error("result loaded without a pending result");

	// A stored value is only written while no pair or overflow is recorded and the table has room.
	a_store_guard: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !pair_q && !exceed_q && count_q < FULL_COUNT)
		else $error("store after pair or overflow");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for complement_pair_search_unit.
// Depends on cps_pkg and the block's RTL. It streams directed and random arrays
// and checks each result word against its own model of the pair search.
module tb;

	localparam int DEPTH     = cps_pkg::DEFAULT_TABLE_DEPTH;
	// Cycles with no handshake on either side before the run is abandoned.
	localparam int STALL_LIM = 20000;
	// Quiet time after the last result.
	localparam int SETTLE    = DEPTH + 40;
	localparam int LONG_HOLD = 600;
	localparam int PHASES    = 6;
	localparam int PHASE_LEN = 230;
	localparam int DIR_N     = 19;

	typedef struct packed {
		cps_pkg::status_t status;
		logic [7:0]       first_idx;
		logic [7:0]       second_idx;
	} pair_result_t;

	typedef struct packed {
		logic [31:0]  value;
		logic         last;
		logic         typed;      // result below replaces the model's prediction
		logic         typed_has;  // typed row produces a result word
		pair_result_t typed_res;
	} array_word_t;

	localparam pair_result_t NO_RES = '{cps_pkg::STATUS_PAIR, 8'd0, 8'd0};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;   // [31:0] value
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // [7:0] first_index, [15:8] second_index
	logic [1:0]  m_tuser;          // [1:0] status

	complement_pair_search_unit #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Directed arrays, written against the reset target of zero.
	array_word_t dir_table [DIR_N] = '{
		// Pair completed on the last word.
		'{32'sd5,         1'b0, 1'b0, 1'b0, NO_RES},
		'{-32'sd5,        1'b1, 1'b1, 1'b1, '{cps_pkg::STATUS_PAIR, 8'd0, 8'd1}},
		// Single-element array.
		'{32'sd7,         1'b1, 1'b1, 1'b1, '{cps_pkg::STATUS_NONE, 8'd0, 8'd0}},
		// Duplicate values: the lowest position wins.
		'{32'sd3,         1'b0, 1'b0, 1'b0, NO_RES},
		'{32'sd3,         1'b0, 1'b0, 1'b0, NO_RES},
		'{-32'sd3,        1'b1, 1'b0, 1'b0, NO_RES},
		// Pair early, then words that are ignored up to the last one.
		'{32'sd0,         1'b0, 1'b0, 1'b0, NO_RES},
		'{32'sd0,         1'b0, 1'b0, 1'b0, NO_RES},
		'{32'sd9,         1'b0, 1'b0, 1'b0, NO_RES},
		'{-32'sd9,        1'b1, 1'b1, 1'b0, NO_RES},
		// Most negative value: its complement needs the 33rd bit.
		'{32'h8000_0000,  1'b0, 1'b0, 1'b0, NO_RES},
		'{32'h8000_0000,  1'b1, 1'b1, 1'b1, '{cps_pkg::STATUS_NONE, 8'd0, 8'd0}},
		// Most positive value paired with its negation.
		'{32'h7FFF_FFFF,  1'b0, 1'b0, 1'b0, NO_RES},
		'{32'h8000_0001,  1'b1, 1'b1, 1'b1, '{cps_pkg::STATUS_PAIR, 8'd0, 8'd1}},
		// All-ones words and a pair on a middle word.
		'{32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, NO_RES},
		'{32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, NO_RES},
		'{32'sd1,         1'b0, 1'b0, 1'b0, NO_RES},
		'{32'sd2,         1'b1, 1'b1, 1'b0, NO_RES},
		// A lone zero finds no partner.
		'{32'sd0,         1'b1, 1'b1, 1'b1, '{cps_pkg::STATUS_NONE, 8'd0, 8'd0}}
	};

	// Search state kept alongside the block.
	logic [31:0]  target_reg = '0;
	logic [31:0]  seen_vals [DEPTH];
	int           fill_cnt    = 0;
	logic         pair_done   = 1'b0;
	logic         over_flag   = 1'b0;

	array_word_t  word_feed [$];
	pair_result_t expected_results [$];
	array_word_t  cur_word;
	int           send_idle  = 0;
	int           recv_idle  = 0;
	int           errors     = 0;
	int           quiet      = 0;
	int           hold_req   = 0;
	int           hold_ack   = 0;
	int           hold_left  = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One element of the pair search; returns the result word it causes, if any.
	function automatic void search_element(input logic [31:0] v, input logic lst,
			output logic has, output pair_result_t r);
		logic signed [32:0] want;
		int hit;
		int i;
		has = 1'b0;
		r   = NO_RES;
		hit = -1;
		if (!pair_done && !over_flag) begin
			if (fill_cnt >= DEPTH) begin
				over_flag = 1'b1;
			end else begin
				want = $signed({target_reg[31], target_reg}) - $signed({v[31], v});
				for (i = 0; i < fill_cnt; i++) begin
					if (hit < 0 && $signed({seen_vals[i][31], seen_vals[i]}) == want) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					has          = 1'b1;
					r.status     = cps_pkg::STATUS_PAIR;
					r.first_idx  = hit[7:0];
					r.second_idx = fill_cnt[7:0];
					pair_done    = 1'b1;
				end else begin
					seen_vals[fill_cnt] = v;
					fill_cnt++;
				end
			end
		end
		if (lst) begin
			if (!has && !pair_done) begin
				has      = 1'b1;
				r.status = over_flag ? cps_pkg::STATUS_OVERFLOW : cps_pkg::STATUS_NONE;
			end
			fill_cnt  = 0;
			pair_done = 1'b0;
			over_flag = 1'b0;
		end
	endfunction

	// Queues one random array and returns its length.
	function automatic int push_random_array();
		logic [31:0] vals [$];
		logic [32:0] want;
		logic [31:0] v;
		int len;
		int style;
		int pick;
		int i;
		int j;
		int k;
		pick = $urandom_range(9);
		if (pick < 7) begin
			len = $urandom_range(2, 10);
		end else if (pick < 9) begin
			len = $urandom_range(11, 48);
		end else begin
			len = 1;
		end
		style = $urandom_range(3);
		for (i = 0; i < len; i++) begin
			case (style)
				1: begin
					// Values close to half the target collide often.
					v = {target_reg[31], target_reg[31:1]} + 32'($urandom_range(0, 8)) - 32'd4;
				end
				3: begin
					case ($urandom_range(5))
						0: v = 32'h8000_0000;
						1: v = 32'h7FFF_FFFF;
						2: v = 32'h0000_0000;
						3: v = 32'hFFFF_FFFF;
						4: v = 32'h0000_0001;
						default: v = target_reg;
					endcase
				end
				default: v = $urandom();
			endcase
			vals.insert(vals.size(), v);
		end
		// Plant a pair where the complement is representable.
		if (style == 2 && len >= 2) begin
			j    = $urandom_range(0, len - 2);
			k    = $urandom_range(j + 1, len - 1);
			want = {target_reg[31], target_reg} - {vals[j][31], vals[j]};
			if (want[32] == want[31]) begin
				vals[k] = want[31:0];
			end
		end
		for (i = 0; i < len; i++) begin
			word_feed.insert(word_feed.size(),
				array_word_t'{vals[i], i == len - 1, 1'b0, 1'b0, NO_RES});
		end
		return len;
	endfunction

	// Ascending positive values with a chosen final word; used with a zero target.
	task automatic push_ramp(input int len, input logic [31:0] tail);
		int i;
		for (i = 0; i < len - 1; i++) begin
			word_feed.insert(word_feed.size(),
				array_word_t'{32'(i + 1), 1'b0, 1'b0, 1'b0, NO_RES});
		end
		word_feed.insert(word_feed.size(), array_word_t'{tail, 1'b1, 1'b0, 1'b0, NO_RES});
	endtask

	task automatic write_target(input logic [31:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		target_reg = v;
	endtask

	// Waits until every word has gone in and every result has come out.
	task automatic drain_all();
		while (word_feed.size() != 0 || s_tvalid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Input side: predict each accepted word, then offer the next one.
	always @(posedge clk) begin
		logic         has;
		pair_result_t r;
		if (s_tvalid && s_tready) begin
			search_element(cur_word.value, cur_word.last, has, r);
			if (cur_word.typed) begin
				has = cur_word.typed_has;
				r   = cur_word.typed_res;
			end
			if (has) begin
				expected_results.insert(expected_results.size(), r);
			end
		end
		if (!s_tvalid || s_tready) begin
			if (word_feed.size() != 0 && $urandom_range(99) >= send_idle) begin
				cur_word = word_feed.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= cur_word.value;
				s_tlast  <= cur_word.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output side: compare each result word with the oldest expectation.
	always @(posedge clk) begin
		pair_result_t e;
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				note_error($sformatf("unexpected result word: status %0d first %0d second %0d",
					m_tuser, m_tdata[7:0], m_tdata[15:8]));
			end else begin
				e = expected_results.pop_front();
				if (m_tuser != e.status || m_tdata[7:0] != e.first_idx ||
						m_tdata[15:8] != e.second_idx) begin
					note_error($sformatf(
						"mismatch: expected status %0d first %0d second %0d, got %0d %0d %0d",
						e.status, e.first_idx, e.second_idx,
						m_tuser, m_tdata[7:0], m_tdata[15:8]));
				end
			end
		end
		// A long hold-off, requested by the sequence, lets the block back up.
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog on handshake progress.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= STALL_LIM) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Test sequence: phases of target settings and idling patterns.
	initial begin
		int phase;
		int budget;
		int i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase / 2)
				0: begin send_idle = 32; recv_idle = 60; end
				1: begin send_idle = 60; recv_idle = 32; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			case (phase)
				1: write_target(32'h8000_0000);
				2: write_target(32'h7FFF_FFFF);
				3: write_target($urandom());
				4: write_target(32'hFFFF_FFFF);
				5: write_target(32'($urandom_range(0, 40)) - 32'd20);
				default: ;
			endcase
			if (phase == 0) begin
				for (i = 0; i < DIR_N; i++) begin
					word_feed.insert(word_feed.size(), dir_table[i]);
				end
				// Full table with the pair on its final entry, then one word too many.
				push_ramp(DEPTH, 32'hFFFF_FFFF);
				push_ramp(DEPTH + 1, 32'hFFFF_FFFF);
			end
			if (phase == 4) begin
				hold_req++;
			end
			budget = PHASE_LEN;
			while (budget > 0) begin
				budget -= push_random_array();
			end
			drain_all();
		end
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/cps_pkg.sv
hdl/cps_value_ram.sv
hdl/cps_search_ctrl.sv
hdl/complement_pair_search_unit.sv
verif/tb.sv
